>>> rtl/page_framebuffer_draw_engine_unit_macros.svh
// Assertion macros for the page frame buffer draw engine.
// No dependencies; included by the top level only.
`ifndef PAGE_FRAMEBUFFER_DRAW_ENGINE_UNIT_MACROS_SVH
`define PAGE_FRAMEBUFFER_DRAW_ENGINE_UNIT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define PFDE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define PFDE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/pfde_pkg.sv
// Shared types and constants for the page frame buffer draw engine.
// No dependencies.
`timescale 1ns / 1ps
package pfde_pkg;
    localparam int WIDTH_DEF  = 128;
    localparam int HEIGHT_DEF = 64;

    typedef enum logic [2:0] {
        ACT_SET   = 3'd0,
        ACT_CLR   = 3'd1,
        ACT_FILL  = 3'd2,
        ACT_CLEAR = 3'd3,
        ACT_LINE  = 3'd4,
        ACT_READ  = 3'd5,
        ACT_NOP6  = 3'd6,
        ACT_NOP7  = 3'd7
    } t_action;

    typedef enum logic [1:0] {
        REG_LEFT   = 2'd0,
        REG_TOP    = 2'd1,
        REG_RIGHT  = 2'd2,
        REG_BOTTOM = 2'd3
    } t_reg_idx;

    // Classified command handed from front to back.
    typedef struct packed {
        t_action    action;
        logic       reject;
        logic [7:0] x1;
        logic [7:0] y1;
        logic [7:0] x2;
        logic [7:0] y2;
        logic [9:0] addr;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_CLEARMEM,
        ST_IDLE,
        ST_RMW_READ,
        ST_RMW_WRITE,
        ST_LINE_STEP,
        ST_READ_WAIT,
        ST_DONE
    } t_state;
endpackage

>>> rtl/pfde_front.sv
// Front end: offsets coordinates into the clip window, clips, checks start point.
// Depends on pfde_pkg.
`timescale 1ns / 1ps
module pfde_front
    import pfde_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_action,
    input  logic [7:0] i_pos_x1,
    input  logic [7:0] i_pos_y1,
    input  logic [7:0] i_pos_x2,
    input  logic [7:0] i_pos_y2,
    input  logic [9:0] i_byte_addr,
    input  logic [7:0] i_win_left,
    input  logic [7:0] i_win_top,
    input  logic [7:0] i_win_right,
    input  logic [7:0] i_win_bottom,
    output logic       o_cmd_valid,
    input  logic       i_cmd_ready,
    output t_cmd       o_cmd
);
    // Two-entry queue toward the back end.
    t_cmd       r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       r_wr;
    t_cmd       w_cmd;
    logic [7:0] w_x1, w_y1, w_x2, w_y2;
    logic       w_push, w_pop;
    t_action    w_act;

    always_comb begin
        w_act = t_action'(i_action);
        w_x1 = i_pos_x1 + i_win_left;
        w_y1 = i_pos_y1 + i_win_top;
        w_x2 = i_pos_x2 + i_win_left;
        w_y2 = i_pos_y2 + i_win_top;
        w_cmd.action = w_act;
        w_cmd.x1 = w_x1;
        w_cmd.y1 = w_y1;
        w_cmd.addr = i_byte_addr;
        w_cmd.reject = (w_x1 > i_win_right) || (w_y1 > i_win_bottom);
        if (w_act == ACT_LINE) begin
            w_cmd.x2 = w_x2;
            w_cmd.y2 = w_y2;
            if (w_x1 < i_win_left || w_y1 < i_win_top) w_cmd.reject = 1'b1;
        end else begin
            // rectangle ends saturate to the window edge
            w_cmd.x2 = (w_x2 > i_win_right) ? i_win_right : w_x2;
            w_cmd.y2 = (w_y2 > i_win_bottom) ? i_win_bottom : w_y2;
        end
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign w_push      = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign w_pop       = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (w_push) begin
                r_q[r_wr] <= w_cmd;
                r_wr <= ~r_wr;
            end
            if (w_pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

>>> rtl/pfde_back.sv
// Back end: executes commands on the page-organized pixel memory.
// Depends on pfde_pkg.
`timescale 1ns / 1ps
module pfde_back
    import pfde_pkg::*;
#(
    parameter int WIDTH  = WIDTH_DEF,
    parameter int HEIGHT = HEIGHT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    output logic       o_cmd_ready,
    input  t_cmd       i_cmd,
    input  logic [7:0] i_win_left,
    input  logic [7:0] i_win_top,
    input  logic [7:0] i_win_right,
    input  logic [7:0] i_win_bottom,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_read_byte,
    output logic       o_status,
    output logic       o_busy
);
    localparam int PAGES = (HEIGHT + 7) / 8;
    localparam int SIZE  = WIDTH * PAGES;
    localparam int AW    = $clog2(SIZE);

    logic [7:0] r_mem [SIZE];
    logic [7:0] r_rdata;

    t_state r_state, n_state;
    t_cmd   r_cmd;
    logic [7:0] r_x, r_y;        // current column / pixel row (page in r_page for rects)
    logic [4:0] r_page;
    logic signed [9:0] r_err;
    logic [8:0] r_dx, r_dy;
    logic       r_sx, r_sy;
    logic [AW:0] r_clr;
    logic       r_ovalid;
    logic [7:0] r_obyte;
    logic       r_ostat;

    // memory port signals
    logic          w_we;
    logic [AW-1:0] w_addr;
    logic [7:0]    w_wdata;
    logic [7:0]    w_mask;
    logic          w_or;
    logic          w_inst;
    logic [15:0]   w_lin;

    // rectangle/pixel bookkeeping
    logic [4:0] w_last_page;
    logic [7:0] w_rmask;
    logic       w_fill;
    logic       w_inwin;
    logic signed [10:0] w_e2;
    logic       w_stepx, w_stepy;

    assign o_valid     = r_ovalid;
    assign o_read_byte = r_obyte;
    assign o_status    = r_ostat;
    assign o_busy      = (r_state != ST_IDLE) || r_ovalid;

    assign w_last_page = r_cmd.y2[7:3];
    assign w_fill = (r_cmd.action == ACT_FILL) || (r_cmd.action == ACT_SET)
                 || (r_cmd.action == ACT_LINE);
    assign w_lin  = 16'(r_x) + 16'(r_page) * 16'(WIDTH);
    assign w_inst = (r_x < 8'(WIDTH)) && (32'(r_page) < 32'(PAGES));

    // byte mask for the current page
    always_comb begin
        w_rmask = 8'hff;
        if (r_cmd.action == ACT_SET || r_cmd.action == ACT_CLR
            || r_cmd.action == ACT_LINE) begin
            w_rmask = 8'h01 << r_y[2:0];
        end else begin
            if (r_page == r_cmd.y1[7:3]) w_rmask = w_rmask & (8'hff << r_cmd.y1[2:0]);
            if (r_page == w_last_page)   w_rmask = w_rmask & ~(8'hfe << r_cmd.y2[2:0]);
        end
        w_mask = w_rmask;
        w_or   = w_fill;
    end

    assign w_inwin = (r_x >= i_win_left) && (r_x <= i_win_right)
                  && (r_y >= i_win_top) && (r_y <= i_win_bottom);
    assign w_e2    = {r_err, 1'b0};
    assign w_stepx = w_e2 > -$signed({2'b0, r_dy});
    assign w_stepy = w_e2 < $signed({2'b0, r_dx});

    always_comb begin
        w_we    = 1'b0;
        w_addr  = w_lin[AW-1:0];
        w_wdata = w_or ? (r_rdata | w_mask) : (r_rdata & ~w_mask);
        if (r_state == ST_CLEARMEM) begin
            w_we = 1'b1;
            w_addr = r_clr[AW-1:0];
            w_wdata = 8'h00;
        end else if (r_state == ST_RMW_WRITE) begin
            w_we = w_inst;
        end else if (r_state == ST_IDLE) begin
            w_addr = i_cmd.addr[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_addr] <= w_wdata;
        r_rdata <= r_mem[w_addr];
    end

    assign o_cmd_ready = (r_state == ST_IDLE) && !r_ovalid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEARMEM:  if (r_clr == (AW+1)'(SIZE - 1)) n_state = ST_IDLE;
            ST_IDLE: begin
                if (i_cmd_valid && o_cmd_ready) begin
                    unique case (i_cmd.action)
                        ACT_SET, ACT_CLR, ACT_FILL, ACT_CLEAR, ACT_LINE:
                            n_state = i_cmd.reject ? ST_DONE : ST_RMW_READ;
                        ACT_READ: n_state = ST_READ_WAIT;
                        default:  n_state = ST_DONE;
                    endcase
                end
            end
            ST_RMW_READ:  n_state = ST_RMW_WRITE;
            ST_RMW_WRITE: begin
                if (r_cmd.action == ACT_LINE) n_state = ST_LINE_STEP;
                else if (r_cmd.action == ACT_SET || r_cmd.action == ACT_CLR) n_state = ST_DONE;
                else if (r_x >= r_cmd.x2 && r_page >= w_last_page) n_state = ST_DONE;
                else n_state = ST_RMW_READ;
            end
            ST_LINE_STEP: n_state = ST_RMW_READ;
            ST_READ_WAIT: n_state = ST_DONE;
            ST_DONE:      n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
        // line termination checks
        if (r_state == ST_RMW_WRITE && r_cmd.action == ACT_LINE
            && r_x == r_cmd.x2 && r_y == r_cmd.y2) n_state = ST_DONE;
        if (r_state == ST_LINE_STEP && !w_inwin) n_state = ST_DONE;
        // rectangle with end before start covers nothing
        if (r_state == ST_RMW_READ && (r_cmd.action == ACT_FILL || r_cmd.action == ACT_CLEAR)
            && (r_cmd.x2 < r_cmd.x1 || r_cmd.y2 < r_cmd.y1)) n_state = ST_DONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEARMEM;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEARMEM) r_clr <= r_clr + 1'b1;
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            if (r_state == ST_DONE) r_ovalid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                // load only on a taken command; a waiting result keeps its data
                if (i_cmd_valid && o_cmd_ready) begin
                    r_cmd   <= i_cmd;
                    r_x     <= i_cmd.x1;
                    r_y     <= i_cmd.y1;
                    r_page  <= i_cmd.y1[7:3];
                    r_dx    <= (i_cmd.x2 > i_cmd.x1) ? 9'(i_cmd.x2 - i_cmd.x1)
                                                     : 9'(i_cmd.x1 - i_cmd.x2);
                    r_dy    <= (i_cmd.y2 > i_cmd.y1) ? 9'(i_cmd.y2 - i_cmd.y1)
                                                     : 9'(i_cmd.y1 - i_cmd.y2);
                    r_sx    <= i_cmd.x1 > i_cmd.x2;
                    r_sy    <= i_cmd.y1 > i_cmd.y2;
                    r_err   <= (i_cmd.x2 > i_cmd.x1 ? 10'(i_cmd.x2 - i_cmd.x1)
                                                    : 10'(i_cmd.x1 - i_cmd.x2))
                             - (i_cmd.y2 > i_cmd.y1 ? 10'(i_cmd.y2 - i_cmd.y1)
                                                    : 10'(i_cmd.y1 - i_cmd.y2));
                    r_ostat <= i_cmd.reject && (i_cmd.action != ACT_READ)
                            && (i_cmd.action != ACT_NOP6) && (i_cmd.action != ACT_NOP7);
                    r_obyte <= 8'h00;
                end
            end
            ST_RMW_WRITE: begin
                if (r_cmd.action == ACT_FILL || r_cmd.action == ACT_CLEAR) begin
                    if (r_x >= r_cmd.x2) begin
                        r_x    <= r_cmd.x1;
                        r_page <= r_page + 5'd1;
                    end else begin
                        r_x <= r_x + 8'd1;
                    end
                end else if (r_cmd.action == ACT_LINE) begin
                    if (w_stepx) r_x <= r_sx ? r_x - 8'd1 : r_x + 8'd1;
                    if (w_stepy) r_y <= r_sy ? r_y - 8'd1 : r_y + 8'd1;
                    r_err <= r_err - (w_stepx ? $signed({1'b0, r_dy}) : 10'sd0)
                                   + (w_stepy ? $signed({1'b0, r_dx}) : 10'sd0);
                end
            end
            ST_LINE_STEP: r_page <= r_y[7:3];
            ST_READ_WAIT: begin
                r_obyte <= (32'(r_cmd.addr) < 32'(SIZE)) ? r_rdata : 8'h00;
            end
            default: ;
        endcase
    end
endmodule

>>> rtl/page_framebuffer_draw_engine_unit.sv
// Top level of the page frame buffer draw engine: config registers, front, back.
// Depends on pfde_pkg, pfde_front, pfde_back and the macros header.
`timescale 1ns / 1ps
// A command transaction on the input channel is classified by the front end (window
// offset, clipping, start check) and queued in a two-deep queue; the back end then works
// it against a single-port byte memory of WIDTH*ceil(HEIGHT/8) bytes using
// read-modify-write of each touched byte, with a step state between line pixels.
// After reset a clearing pass writes zero to every byte, one per cycle (1024 bytes at
// default size), before any command is taken; config writes are accepted throughout.
// One result transaction per command.
`include "page_framebuffer_draw_engine_unit_macros.svh"
module page_framebuffer_draw_engine_unit
    import pfde_pkg::*;
#(
    parameter int WIDTH  = WIDTH_DEF,
    parameter int HEIGHT = HEIGHT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_action,
    input  logic [7:0] i_pos_x1,
    input  logic [7:0] i_pos_y1,
    input  logic [7:0] i_pos_x2,
    input  logic [7:0] i_pos_y2,
    input  logic [9:0] i_byte_addr,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_read_byte,
    output logic       o_status
);
    logic [7:0] r_win_left, r_win_top, r_win_right, r_win_bottom;
    logic       w_cmd_valid, w_cmd_ready, w_busy;
    t_cmd       w_cmd;

    // Window registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_left   <= 8'd0;
            r_win_top    <= 8'd0;
            r_win_right  <= 8'd127;
            r_win_bottom <= 8'd63;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_LEFT:   r_win_left   <= i_cfg_data;
                REG_TOP:    r_win_top    <= i_cfg_data;
                REG_RIGHT:  r_win_right  <= i_cfg_data;
                REG_BOTTOM: r_win_bottom <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pfde_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_action, .i_pos_x1, .i_pos_y1, .i_pos_x2, .i_pos_y2, .i_byte_addr,
        .i_win_left(r_win_left), .i_win_top(r_win_top),
        .i_win_right(r_win_right), .i_win_bottom(r_win_bottom),
        .o_cmd_valid(w_cmd_valid), .i_cmd_ready(w_cmd_ready), .o_cmd(w_cmd)
    );

    pfde_back #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid(w_cmd_valid), .o_cmd_ready(w_cmd_ready), .i_cmd(w_cmd),
        .i_win_left(r_win_left), .i_win_top(r_win_top),
        .i_win_right(r_win_right), .i_win_bottom(r_win_bottom),
        .o_valid, .i_ready, .o_read_byte, .o_status, .o_busy(w_busy)
    );

    // A result is only presented while the back end holds it.
    `PFDE_ASSERT_IMPL(a_valid_busy, i_clk, i_rst_n, o_valid, w_busy, "result without busy")
    // A rejected result never carries read data.
    `PFDE_ASSERT_IMPL(a_rej_zero, i_clk, i_rst_n, o_valid && o_status, o_read_byte == 8'h00,
        "rejected result has data")
    // A command is never handed over while a result waits.
    `PFDE_ASSERT_IMPL(a_no_overlap, i_clk, i_rst_n, w_cmd_valid && w_cmd_ready, !o_valid,
        "command taken with result pending")
endmodule
